>>> src/queue_with_move_to_front_assert.svh
// Assertion macros shared by the queue RTL. The enclosing module must
// provide clk and rst_n.
`ifndef QUEUE_WITH_MOVE_TO_FRONT_ASSERT_SVH
`define QUEUE_WITH_MOVE_TO_FRONT_ASSERT_SVH

// Same-cycle implication, checked only out of reset.
`define QMTF_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked only out of reset.
`define QMTF_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> src/qmtf_pkg.sv
package qmtf_pkg;

  localparam int DEPTH      = 16;
  localparam int DATA_WIDTH = 16;
  localparam int AW         = $clog2(DEPTH);
  localparam int CW         = $clog2(DEPTH + 1);

  // Fixed port widths.
  localparam int OP_W   = 3;
  localparam int VAL_W  = 16;
  localparam int POS_W  = 4;
  localparam int STAT_W = 3;
  localparam int CNT_W  = 5;

  typedef enum logic [OP_W-1:0] {
    OP_ENQUEUE = 3'd0,
    OP_DEQUEUE = 3'd1,
    OP_MOVE    = 3'd2,
    OP_REMOVE  = 3'd3,
    OP_READ    = 3'd4
  } op_t;

  typedef enum logic [STAT_W-1:0] {
    STAT_OK    = 3'd0,
    STAT_EMPTY = 3'd1,
    STAT_NOKEY = 3'd2,
    STAT_POS   = 3'd3,
    STAT_FULL  = 3'd4
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SEARCH,
    S_SHIFT,
    S_RDCAP,
    S_FRONT,
    S_DONE
  } state_t;

endpackage

>>> src/qmtf_ram.sv
// Simple dual-port RAM: one write port, one read port, registered read data.
module qmtf_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> src/queue_with_move_to_front.sv
// Bounded ordered queue of up to DEPTH values with move-to-front. Each input
// transaction carries one operation (enqueue, dequeue, move key to front,
// remove key, read position) and produces exactly one result transaction with
// status, read value, front entry, empty flag and entry count, all taken after
// the operation. Entries live in a single-port-write, registered-read RAM in
// queue order with the front at address zero, and a small sequencer walks
// that RAM one address per cycle, with one shared key comparator. The block
// takes one transaction at a time: in_ready is high only while no operation
// is in progress, so the next transaction can be taken in the same cycle
// that a result appears.
module queue_with_move_to_front (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [qmtf_pkg::OP_W-1:0]    in_op,
  input  logic [qmtf_pkg::VAL_W-1:0]   in_value,
  input  logic [qmtf_pkg::POS_W-1:0]   in_position,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [qmtf_pkg::STAT_W-1:0]  out_status,
  output logic [qmtf_pkg::VAL_W-1:0]   out_read_value,
  output logic [qmtf_pkg::VAL_W-1:0]   out_front_value,
  output logic                         out_is_empty,
  output logic [qmtf_pkg::CNT_W-1:0]   out_entry_count
);

  import qmtf_pkg::*;

  `include "queue_with_move_to_front_assert.svh"

  // Sequencer state and per-transaction context.
  state_t                state_r, state_nxt;
  op_t                   op_r, op_nxt;
  logic [DATA_WIDTH-1:0] key_r, key_nxt;
  status_t               status_r, status_nxt;
  logic [DATA_WIDTH-1:0] rd_r, rd_nxt;

  // Queue occupancy.
  logic [CW-1:0]         cnt_r, cnt_nxt;

  // Walk pointers: src is the next read address, dst the next write address,
  // left counts the reads still to issue during a shift.
  logic [CW-1:0]         src_r, src_nxt;
  logic [CW-1:0]         dst_r, dst_nxt;
  logic [CW-1:0]         left_r, left_nxt;
  logic                  launched_r, launched_nxt;

  // Result register.
  logic                  out_valid_r, out_valid_nxt;
  status_t               out_status_r, out_status_nxt;
  logic [VAL_W-1:0]      out_rd_r, out_rd_nxt;
  logic [VAL_W-1:0]      out_front_r, out_front_nxt;
  logic                  out_empty_r, out_empty_nxt;
  logic [CW-1:0]         out_cnt_r, out_cnt_nxt;

  // RAM port signals.
  logic                  ram_we;
  logic [AW-1:0]         ram_waddr;
  logic [DATA_WIDTH-1:0] ram_wdata;
  logic [AW-1:0]         ram_raddr;
  logic [DATA_WIDTH-1:0] ram_rdata;

  logic                  in_fire;
  logic                  key_hit;
  logic [CW-1:0]         hit_idx;
  logic                  shift_up;
  logic                  pos_beyond;

  qmtf_ram #(
    .WIDTH (DATA_WIDTH),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign in_ready = (state_r == S_IDLE);
  assign in_fire  = in_valid && in_ready;

  // The one shared comparator: RAM read data against the search key.
  assign key_hit  = (ram_rdata == key_r);
  // Read data in the search always belongs to the address issued last cycle.
  assign hit_idx  = src_r - CW'(1);
  // Dequeue and remove close a gap moving toward the front; move-to-front
  // opens a slot at the front by moving entries toward the back.
  assign shift_up = (op_r != OP_MOVE);

  assign pos_beyond = ({{CW{1'b0}}, in_position} >= {{POS_W{1'b0}}, cnt_r});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      launched_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      launched_r  <= launched_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload and pointer registers need no reset.
  always_ff @(posedge clk) begin
    op_r         <= op_nxt;
    key_r        <= key_nxt;
    status_r     <= status_nxt;
    rd_r         <= rd_nxt;
    src_r        <= src_nxt;
    dst_r        <= dst_nxt;
    left_r       <= left_nxt;
    out_status_r <= out_status_nxt;
    out_rd_r     <= out_rd_nxt;
    out_front_r  <= out_front_nxt;
    out_empty_r  <= out_empty_nxt;
    out_cnt_r    <= out_cnt_nxt;
  end

  always_comb begin
    state_nxt      = state_r;
    op_nxt         = op_r;
    key_nxt        = key_r;
    status_nxt     = status_r;
    rd_nxt         = rd_r;
    cnt_nxt        = cnt_r;
    src_nxt        = src_r;
    dst_nxt        = dst_r;
    left_nxt       = left_r;
    launched_nxt   = launched_r;
    out_valid_nxt  = out_valid_r;
    out_status_nxt = out_status_r;
    out_rd_nxt     = out_rd_r;
    out_front_nxt  = out_front_r;
    out_empty_nxt  = out_empty_r;
    out_cnt_nxt    = out_cnt_r;
    ram_we         = 1'b0;
    ram_waddr      = '0;
    ram_wdata      = key_r;
    // Address zero is read by default, so the front entry sits on the read
    // data while a finished result waits for the output register.
    ram_raddr      = '0;

    // A waiting result leaves as soon as the consumer takes it.
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      S_IDLE: begin
        // Start the read for a position lookup right away; it is only used
        // when the position turns out to be inside the queue.
        ram_raddr = AW'(in_position);
        if (in_fire) begin
          op_nxt       = op_t'(in_op);
          key_nxt      = in_value[DATA_WIDTH-1:0];
          status_nxt   = STAT_OK;
          rd_nxt       = '0;
          src_nxt      = '0;
          launched_nxt = 1'b0;
          state_nxt    = S_FRONT;
          case (op_t'(in_op))
            OP_ENQUEUE: begin
              if (cnt_r == CW'(DEPTH)) begin
                status_nxt = STAT_FULL;
              end else begin
                ram_we    = 1'b1;
                ram_waddr = cnt_r[AW-1:0];
                ram_wdata = in_value[DATA_WIDTH-1:0];
                cnt_nxt   = cnt_r + CW'(1);
              end
            end
            OP_DEQUEUE: begin
              if (cnt_r == '0) begin
                status_nxt = STAT_EMPTY;
              end else begin
                // Close the gap at the front: entry i+1 moves to entry i.
                dst_nxt   = '0;
                src_nxt   = CW'(1);
                left_nxt  = cnt_r - CW'(1);
                state_nxt = S_SHIFT;
              end
            end
            OP_MOVE, OP_REMOVE: begin
              if (cnt_r == '0) begin
                status_nxt = STAT_EMPTY;
              end else begin
                state_nxt = S_SEARCH;
              end
            end
            OP_READ: begin
              if (cnt_r == '0) begin
                status_nxt = STAT_EMPTY;
              end else if (pos_beyond) begin
                status_nxt = STAT_POS;
              end else begin
                state_nxt = S_RDCAP;
              end
            end
            default: begin
              // Unused op codes leave the queue as it is and report OK.
            end
          endcase
        end
      end

      S_SEARCH: begin
        // One read issued per cycle, compared in the next cycle; the first
        // match, nearest the front, wins.
        if (launched_r && key_hit) begin
          launched_nxt = 1'b0;
          dst_nxt      = hit_idx;
          if (op_r == OP_MOVE) begin
            if (hit_idx == '0) begin
              // Key already at the front: nothing moves.
              state_nxt = S_FRONT;
            end else begin
              src_nxt   = hit_idx - CW'(1);
              left_nxt  = hit_idx;
              state_nxt = S_SHIFT;
            end
          end else begin
            src_nxt   = hit_idx + CW'(1);
            left_nxt  = cnt_r - CW'(1) - hit_idx;
            state_nxt = S_SHIFT;
          end
        end else if (src_r < cnt_r) begin
          ram_raddr    = src_r[AW-1:0];
          src_nxt      = src_r + CW'(1);
          launched_nxt = 1'b1;
        end else begin
          launched_nxt = 1'b0;
          if (!launched_r) begin
            status_nxt = STAT_NOKEY;
            state_nxt  = S_FRONT;
          end
        end
      end

      S_SHIFT: begin
        // Pipelined copy: the word read last cycle is written now while the
        // next read goes out. Writes trail reads, so no entry is overwritten
        // before it has been read.
        if (launched_r) begin
          ram_we    = 1'b1;
          ram_waddr = dst_r[AW-1:0];
          ram_wdata = ram_rdata;
          dst_nxt   = shift_up ? (dst_r + CW'(1)) : (dst_r - CW'(1));
        end
        if (left_r != '0) begin
          ram_raddr    = src_r[AW-1:0];
          src_nxt      = shift_up ? (src_r + CW'(1)) : (src_r - CW'(1));
          left_nxt     = left_r - CW'(1);
          launched_nxt = 1'b1;
        end else begin
          launched_nxt = 1'b0;
          if (!launched_r) begin
            if (shift_up) begin
              cnt_nxt = cnt_r - CW'(1);
            end else begin
              // The moved entry equals the key, so the key is written to the
              // front slot that the shift opened.
              ram_we    = 1'b1;
              ram_waddr = '0;
              ram_wdata = key_r;
            end
            state_nxt = S_FRONT;
          end
        end
      end

      S_RDCAP: begin
        rd_nxt    = ram_rdata;
        state_nxt = S_FRONT;
      end

      S_FRONT: begin
        // All writes are done; address zero is read this cycle.
        state_nxt = S_DONE;
      end

      S_DONE: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = status_r;
          out_rd_nxt     = VAL_W'(rd_r);
          out_front_nxt  = (cnt_r == '0) ? '0 : VAL_W'(ram_rdata);
          out_empty_nxt  = (cnt_r == '0);
          out_cnt_nxt    = cnt_r;
          state_nxt      = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  assign out_valid       = out_valid_r;
  assign out_status      = out_status_r;
  assign out_read_value  = out_rd_r;
  assign out_front_value = out_front_r;
  assign out_is_empty    = out_empty_r;
  assign out_entry_count = CNT_W'(out_cnt_r);

  // The count never passes the capacity.
  `QMTF_ASSERT_NOW(a_cnt_bound, 1'b1, cnt_r <= CW'(DEPTH), "entry count above capacity")

  // Every RAM write lands inside the queue or on the slot just past its back.
  `QMTF_ASSERT_NOW(a_wr_in_range, ram_we, CW'(ram_waddr) <= cnt_r, "RAM write beyond back")

  // One transaction changes the count by at most one entry.
  `QMTF_ASSERT_NEXT(a_cnt_step, 1'b1, (cnt_r - $past(cnt_r) + CW'(1)) <= CW'(2), "count jumped")

  // An empty-queue status is only reported for a queue that is still empty.
  `QMTF_ASSERT_NOW(a_empty_status, out_valid_r && (out_status_r == STAT_EMPTY), out_empty_r && (out_front_r == '0), "empty status on a non-empty queue")

endmodule

>>> tb/queue_with_move_to_front_check.sv
`timescale 1ns / 1ps

// Watches both channels of the queue, keeps a shadow copy of its contents and
// compares each result transaction with the report predicted for the oldest
// accepted operation.
module queue_with_move_to_front_check (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  input  logic                         in_ready,
  input  logic [qmtf_pkg::OP_W-1:0]    in_op,
  input  logic [qmtf_pkg::VAL_W-1:0]   in_value,
  input  logic [qmtf_pkg::POS_W-1:0]   in_position,
  input  logic                         out_valid,
  input  logic                         out_ready,
  input  logic [qmtf_pkg::STAT_W-1:0]  out_status,
  input  logic [qmtf_pkg::VAL_W-1:0]   out_read_value,
  input  logic [qmtf_pkg::VAL_W-1:0]   out_front_value,
  input  logic                         out_is_empty,
  input  logic [qmtf_pkg::CNT_W-1:0]   out_entry_count,
  output int                           mismatch_count,
  output int                           awaited_count
);
  import qmtf_pkg::*;

  localparam int PRINT_CAP = 40;

  typedef struct {
    status_t              status;
    logic [VAL_W-1:0]     read_value;
    logic [VAL_W-1:0]     front_value;
    logic                 is_empty;
    logic [CNT_W-1:0]     entry_count;
  } queue_report_t;

  logic [VAL_W-1:0] shadow_entries [DEPTH];
  int               shadow_count = 0;
  queue_report_t    predicted_reports [$];
  queue_report_t    oldest;
  int               mismatches = 0;
  int               result_index = 0;

  assign mismatch_count = mismatches;

  // Only the first few mismatches are printed, so a badly broken block cannot
  // flood the log; every one of them is counted.
  task automatic report_mismatch(input string msg);
    if (mismatches < PRINT_CAP) begin
      $display("%0t ns: result %0d: %s", $time, result_index, msg);
    end
    mismatches++;
  endtask

  function automatic queue_report_t apply_queue_op(input logic [OP_W-1:0] op_code,
                                                   input logic [VAL_W-1:0] key,
                                                   input logic [POS_W-1:0] pos);
    queue_report_t    rep;
    int               hit;
    int               i;
    logic [VAL_W-1:0] lifted;
    rep.status     = STAT_OK;
    rep.read_value = '0;
    // The first match from the front is the one that moves or goes away.
    hit = -1;
    for (i = 0; i < shadow_count; i++) begin
      if (hit < 0 && shadow_entries[i] == key) begin
        hit = i;
      end
    end
    case (op_code)
      OP_ENQUEUE: begin
        if (shadow_count >= DEPTH) begin
          rep.status = STAT_FULL;
        end else begin
          shadow_entries[shadow_count] = key;
          shadow_count++;
        end
      end
      OP_DEQUEUE: begin
        if (shadow_count == 0) begin
          rep.status = STAT_EMPTY;
        end else begin
          for (i = 0; i < shadow_count - 1; i++) begin
            shadow_entries[i] = shadow_entries[i + 1];
          end
          shadow_count--;
        end
      end
      OP_MOVE: begin
        if (shadow_count == 0) begin
          rep.status = STAT_EMPTY;
        end else if (hit < 0) begin
          rep.status = STAT_NOKEY;
        end else begin
          lifted = shadow_entries[hit];
          for (i = hit; i > 0; i--) begin
            shadow_entries[i] = shadow_entries[i - 1];
          end
          shadow_entries[0] = lifted;
        end
      end
      OP_REMOVE: begin
        if (shadow_count == 0) begin
          rep.status = STAT_EMPTY;
        end else if (hit < 0) begin
          rep.status = STAT_NOKEY;
        end else begin
          for (i = hit; i < shadow_count - 1; i++) begin
            shadow_entries[i] = shadow_entries[i + 1];
          end
          shadow_count--;
        end
      end
      OP_READ: begin
        if (shadow_count == 0) begin
          rep.status = STAT_EMPTY;
        end else if (int'(pos) >= shadow_count) begin
          rep.status = STAT_POS;
        end else begin
          rep.read_value = shadow_entries[pos];
        end
      end
      default: begin
      end
    endcase
    rep.front_value = (shadow_count > 0) ? shadow_entries[0] : '0;
    rep.is_empty    = (shadow_count == 0);
    rep.entry_count = CNT_W'(shadow_count);
    return rep;
  endfunction

  // A result accepted at an edge always belongs to an operation accepted at an
  // earlier edge, so results are retired before the new operation is queued.
  always @(posedge clk) begin
    if (!rst_n) begin
      predicted_reports.delete();
      shadow_count = 0;
      awaited_count <= 0;
    end else begin
      if (out_valid && out_ready) begin
        if (predicted_reports.size() == 0) begin
          report_mismatch($sformatf("unexpected result transaction, status %0d",
                                    out_status));
        end else begin
          oldest = predicted_reports.pop_front();
          if (out_status !== oldest.status)
            report_mismatch($sformatf("status %0d, expected %0d",
                                      out_status, oldest.status));
          if (out_read_value !== oldest.read_value)
            report_mismatch($sformatf("read_value %0h, expected %0h",
                                      out_read_value, oldest.read_value));
          if (out_front_value !== oldest.front_value)
            report_mismatch($sformatf("front_value %0h, expected %0h",
                                      out_front_value, oldest.front_value));
          if (out_is_empty !== oldest.is_empty)
            report_mismatch($sformatf("is_empty %0b, expected %0b",
                                      out_is_empty, oldest.is_empty));
          if (out_entry_count !== oldest.entry_count)
            report_mismatch($sformatf("entry_count %0d, expected %0d",
                                      out_entry_count, oldest.entry_count));
        end
        result_index++;
      end
      if (in_valid && in_ready) begin
        predicted_reports.push_back(apply_queue_op(in_op, in_value, in_position));
      end
      awaited_count <= predicted_reports.size();
    end
  end

endmodule

>>> tb/queue_with_move_to_front_tb.sv
`timescale 1ns / 1ps

// Top of the queue testbench. It only generates traffic on the two channels
// and gives the verdict; prediction and comparison live in the check module
// that sits beside the block and watches the same wires.
module queue_with_move_to_front_tb;
  import qmtf_pkg::*;

  // Number of operation transactions in the random part, unused op codes
  // included, since each of them also produces a result.
  localparam int RANDOM_ITEMS = 1525;
  // The tail of the run is sent with no idling on either side.
  localparam int CALM_TAIL    = 150;
  // Wait after the last result, long enough to catch a stray one.
  localparam int SETTLE_CYCLES = 48;
  // The limit is several times the slowest correct run of about 1600 items.
  localparam int TIMEOUT_NS   = 2_000_000;
  localparam int POOL_SIZE    = 6;

  // The op field is three bits wide, so codes five to seven exist on the wire.
  localparam logic [OP_W-1:0] OP_SPARE_5 = 3'd5;
  localparam logic [OP_W-1:0] OP_SPARE_6 = 3'd6;
  localparam logic [OP_W-1:0] OP_SPARE_7 = 3'd7;

  typedef enum {MIX_FILL, MIX_DRAIN, MIX_KEYS, MIX_ANY} mix_t;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_valid = 1'b0;
  logic              in_ready;
  logic [OP_W-1:0]   in_op = '0;
  logic [VAL_W-1:0]  in_value = '0;
  logic [POS_W-1:0]  in_position = '0;
  logic              out_valid;
  logic              out_ready = 1'b0;
  logic [STAT_W-1:0] out_status;
  logic [VAL_W-1:0]  out_read_value;
  logic [VAL_W-1:0]  out_front_value;
  logic              out_is_empty;
  logic [CNT_W-1:0]  out_entry_count;

  int                mismatch_total;
  int                awaited_results;
  // When set, neither side idles. The stimulus process owns this flag and the
  // result-side process only reads it.
  logic              calm = 1'b0;
  logic [VAL_W-1:0]  value_pool [POOL_SIZE];

  queue_with_move_to_front DUT (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_op           (in_op),
    .in_value        (in_value),
    .in_position     (in_position),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_status      (out_status),
    .out_read_value  (out_read_value),
    .out_front_value (out_front_value),
    .out_is_empty    (out_is_empty),
    .out_entry_count (out_entry_count)
  );

  queue_with_move_to_front_check result_check (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_op           (in_op),
    .in_value        (in_value),
    .in_position     (in_position),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_status      (out_status),
    .out_read_value  (out_read_value),
    .out_front_value (out_front_value),
    .out_is_empty    (out_is_empty),
    .out_entry_count (out_entry_count),
    .mismatch_count  (mismatch_total),
    .awaited_count   (awaited_results)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  // Hard stop in case the block hangs or drops a result.
  initial begin
    #(TIMEOUT_NS);
    $display("queue_with_move_to_front_tb NOT OK");
    $finish;
  end

  // The result side stalls in short random bursts unless the run is calm.
  // Each pass assigns out_ready at most once per clock edge.
  initial begin
    forever begin
      @(posedge clk);
      if (!calm && $urandom_range(0, 5) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 4)) @(posedge clk);
      end
      out_ready <= 1'b1;
    end
  end

  // Presents one operation transaction and returns at the edge where it is
  // accepted. Valid is left high, so a following call simply replaces the
  // payload and back-to-back transactions need no extra cycle.
  task automatic offer_transaction(input logic [OP_W-1:0] op_code,
                                   input logic [VAL_W-1:0] key,
                                   input logic [POS_W-1:0] pos);
    in_valid    <= 1'b1;
    in_op       <= op_code;
    in_value    <= key;
    in_position <= pos;
    do @(posedge clk); while (!in_ready);
  endtask

  // Drops valid for a random idle burst.
  task automatic idle_sender();
    in_valid <= 1'b0;
    repeat ($urandom_range(1, 4)) @(posedge clk);
  endtask

  // Stops sending until every expected result has come back. The first edge
  // lets the check module register the transaction that was just accepted.
  task automatic hold_until_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (awaited_results != 0) @(posedge clk);
  endtask

  // Operation mix per phase. Fill phases push the queue to full, drain
  // phases pull it back to empty, and key phases exercise the searches while
  // the queue holds many entries.
  function automatic logic [OP_W-1:0] pick_op(input mix_t mix);
    int roll;
    roll = $urandom_range(0, 99);
    case (mix)
      MIX_FILL: begin
        if (roll < 65) return OP_ENQUEUE;
        if (roll < 72) return OP_DEQUEUE;
        if (roll < 82) return OP_MOVE;
        if (roll < 90) return OP_REMOVE;
        return OP_READ;
      end
      MIX_DRAIN: begin
        if (roll < 15) return OP_ENQUEUE;
        if (roll < 55) return OP_DEQUEUE;
        if (roll < 65) return OP_MOVE;
        if (roll < 85) return OP_REMOVE;
        return OP_READ;
      end
      MIX_KEYS: begin
        if (roll < 25) return OP_ENQUEUE;
        if (roll < 30) return OP_DEQUEUE;
        if (roll < 55) return OP_MOVE;
        if (roll < 75) return OP_REMOVE;
        return OP_READ;
      end
      default: return OP_W'($urandom_range(0, 7));
    endcase
  endfunction

  // Values mostly come from a small pool so that keys hit stored entries and
  // duplicates are common; the rest are fully random and usually miss.
  function automatic logic [VAL_W-1:0] pick_value();
    if ($urandom_range(0, 99) < 80) begin
      return value_pool[$urandom_range(0, POOL_SIZE - 1)];
    end
    return VAL_W'($urandom);
  endfunction

  task automatic refresh_pool();
    int k;
    int roll;
    for (k = 0; k < POOL_SIZE; k++) begin
      roll = $urandom_range(0, 7);
      if (roll == 0) begin
        value_pool[k] = '0;
      end else if (roll == 1) begin
        value_pool[k] = '1;
      end else begin
        value_pool[k] = VAL_W'($urandom);
      end
    end
  endtask

  initial begin
    int               counted;
    int               phase_left;
    logic [OP_W-1:0]  op_code;
    mix_t             mix;

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part. Every operation on an empty queue reports empty.
    offer_transaction(OP_DEQUEUE, 16'h0000, 4'h0);
    offer_transaction(OP_MOVE,    16'hFFFF, 4'hF);
    offer_transaction(OP_REMOVE,  16'h0000, 4'h0);
    offer_transaction(OP_READ,    16'h0000, 4'h0);
    // Removing the only entry leaves the queue empty.
    offer_transaction(OP_ENQUEUE, 16'h0000, 4'hF);
    offer_transaction(OP_REMOVE,  16'h0000, 4'h0);
    // Build FFFF, 1234, FFFF so that a duplicate key sits behind its twin.
    offer_transaction(OP_ENQUEUE, 16'hFFFF, 4'h0);
    offer_transaction(OP_ENQUEUE, 16'h1234, 4'h0);
    offer_transaction(OP_ENQUEUE, 16'hFFFF, 4'h0);
    // Move from the middle, then again with the key already at the front.
    offer_transaction(OP_MOVE,    16'h1234, 4'h0);
    offer_transaction(OP_MOVE,    16'h1234, 4'h0);
    // A missing key changes nothing on move or remove.
    offer_transaction(OP_MOVE,    16'h5555, 4'h0);
    offer_transaction(OP_REMOVE,  16'h5555, 4'h0);
    // Only the first of the two FFFF entries goes away.
    offer_transaction(OP_REMOVE,  16'hFFFF, 4'h0);
    offer_transaction(OP_READ,    16'h0000, 4'h1);
    offer_transaction(OP_READ,    16'h0000, 4'hF);
    // Unused op codes leave the queue alone.
    offer_transaction(OP_SPARE_5, 16'hFFFF, 4'hF);
    offer_transaction(OP_SPARE_6, 16'h0000, 4'h0);
    offer_transaction(OP_SPARE_7, 16'hAAAA, 4'h5);
    // Removing the back entry must leave a correct back for the next enqueue.
    offer_transaction(OP_REMOVE,  16'hFFFF, 4'h0);
    offer_transaction(OP_ENQUEUE, 16'hA5A5, 4'h0);
    offer_transaction(OP_READ,    16'h0000, 4'h1);
    offer_transaction(OP_READ,    16'h0000, 4'h2);

    // The sender waits here for the whole pipeline to empty at least once.
    hold_until_drained();

    // Random part, in phases with their own mix, pool and idling.
    counted    = 0;
    phase_left = 0;
    mix        = MIX_FILL;
    while (counted < RANDOM_ITEMS) begin
      if (phase_left == 0) begin
        // The first phase always fills so that the full case comes early.
        if (counted > 0) begin
          mix = mix_t'($urandom_range(0, 3));
        end
        calm = ($urandom_range(0, 3) == 0);
        refresh_pool();
        phase_left = $urandom_range(20, 60);
        // No pauses of any kind once the calm tail has begun.
        if (counted > 0 && counted < RANDOM_ITEMS - CALM_TAIL &&
            $urandom_range(0, 5) == 0) begin
          hold_until_drained();
        end
      end
      if (counted >= RANDOM_ITEMS - CALM_TAIL) begin
        calm = 1'b1;
      end
      op_code = pick_op(mix);
      offer_transaction(op_code, pick_value(), POS_W'($urandom_range(0, 15)));
      counted++;
      phase_left--;
      if (!calm && $urandom_range(0, 3) == 0) begin
        idle_sender();
      end
    end

    // Wait for the last results, then a little longer for any stray one.
    hold_until_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);

    if (mismatch_total == 0) begin
      $display("queue_with_move_to_front_tb OK");
    end else begin
      $display("queue_with_move_to_front_tb NOT OK");
    end
    $finish;
  end

endmodule

>>> files.f
+incdir+src
src/qmtf_pkg.sv
src/qmtf_ram.sv
src/queue_with_move_to_front.sv
tb/queue_with_move_to_front_check.sv
tb/queue_with_move_to_front_tb.sv
